@@ rtl/fifo_queue_with_sort_unit_defines.svh @@
// ----------------------------------------------------------------------------
// FIFO queue with sort unit: assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SORT_UNIT_DEFINES_SVH
`define FIFO_QUEUE_WITH_SORT_UNIT_DEFINES_SVH

`ifndef SYNTH
// check that is skipped while reset is asserted
`define FQS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fifo queue check failed");
// check that also holds during reset
`define FQS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fifo queue check failed");
`else
`define FQS_ASSERT(lbl, prop)
`define FQS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/fqs_pkg.sv @@
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types and constants of the FIFO queue with sort unit.
// ----------------------------------------------------------------------------
package fqs_pkg;

    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_ROTATE = 2'd2,
        OP_SORT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    typedef struct packed {
        op_t                       operation;
        logic signed [DATA_W-1:0]  push_value;
    } fqs_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  head_value;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      is_empty;
        status_t                   status;
    } fqs_rsp_t;

endpackage

@@ rtl/fqs_ram.sv @@
// ----------------------------------------------------------------------------
// fqs_ram
// Ring store: one write port, one read port, registered read (read-first).
// ----------------------------------------------------------------------------
module fqs_ram
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/fqs_sort.sv @@
// ----------------------------------------------------------------------------
// fqs_sort
// In-place insertion sort sequencer over the ring store. Works in logical
// offsets from the head; the caller maps them to store addresses.
// ----------------------------------------------------------------------------
module fqs_sort
    import fqs_pkg::*;
#(
    parameter int AW = 4,
    parameter int CW = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [CW-1:0]     count,
    input  logic [DATA_W-1:0] rdata,
    output logic [AW-1:0]     rd_off,
    output logic              wr_en,
    output logic [AW-1:0]     wr_off,
    output logic [DATA_W-1:0] wr_data,
    output logic              active,
    output logic              done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY_RD,
        S_KEY_WAIT,
        S_CMP_RD,
        S_CMP,
        S_PLACE,
        S_DONE
    } sort_state_t;

    sort_state_t              state_reg, state_next;
    logic [AW-1:0]            k_reg, k_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                     shift;
    logic                     last_k;

    assign shift  = $signed(rdata) > key_reg;
    assign last_k = (CW'(k_reg) + CW'(1)) == count;

    assign rd_off  = (state_reg == S_KEY_RD) ? k_reg : pos_reg - AW'(1);
    assign wr_off  = pos_reg;
    assign wr_en   = (state_reg == S_CMP) || (state_reg == S_PLACE);
    assign wr_data = (state_reg == S_CMP && shift) ? rdata : key_reg;
    assign active  = state_reg != S_IDLE;
    assign done    = state_reg == S_DONE;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    k_next     = AW'(1);
                    state_next = S_KEY_RD;
                end
            end
            S_KEY_RD:
            begin
                pos_next   = k_reg;
                state_next = S_KEY_WAIT;
            end
            S_KEY_WAIT:
            begin
                key_next   = $signed(rdata);
                state_next = S_CMP_RD;
            end
            S_CMP_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (shift)
                begin
                    // neighbor moved up one slot, keep walking down
                    pos_next   = pos_reg - AW'(1);
                    state_next = (pos_reg == AW'(1)) ? S_PLACE : S_CMP_RD;
                end
                else if (last_k)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = S_KEY_RD;
                end
            end
            S_PLACE:
            begin
                if (last_k)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = S_KEY_RD;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        pos_reg <= pos_next;
        key_reg <= key_next;
    end

endmodule

@@ rtl/fifo_queue_with_sort_unit.sv @@
// Push, pop and rotate: result strobed in the cycle after the accepting edge; busy stays low,
//   so one item is taken every cycle.
// Sort of n >= 2 entries: busy while each key in turn is read, then compared with each earlier
//   entry from the nearest down, each larger one shifted up a slot, and the key written in place;
//   result strobed as busy drops. The single-read-port ring store sets this sequence. Results cannot be stalled.
// Reset clears head, count and control; store contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
// fifo_queue_with_sort_unit
// Bounded FIFO of signed words in a ring store with push, pop, rotate and sort.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_sort_unit_defines.svh"

module fifo_queue_with_sort_unit
    import fqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  fqs_req_t req,
    output logic     done,
    output fqs_rsp_t result
);

    localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = AW + 1;

    typedef enum logic {
        IDLE,
        SORT
    } top_state_t;

    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    top_state_t        state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] head_val_reg, head_val_next;
    logic              pend_reg, pend_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;

    logic              accept;
    logic [DATA_W-1:0] head_cur;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;

    logic              sort_go;
    logic [AW-1:0]     sort_rd_off, sort_wr_off;
    logic              sort_wr_en;
    logic [DATA_W-1:0] sort_wr_data;
    logic              sort_active;
    logic              sort_done;

    fqs_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fqs_sort #(
        .AW (AW),
        .CW (CW)
    ) u_sort (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (sort_go),
        .count   (count_reg),
        .rdata   (mem_rdata),
        .rd_off  (sort_rd_off),
        .wr_en   (sort_wr_en),
        .wr_off  (sort_wr_off),
        .wr_data (sort_wr_data),
        .active  (sort_active),
        .done    (sort_done)
    );

    assign busy   = state_reg == SORT;
    assign accept = start && !busy;
    // head word refreshed by the read issued on the previous beat
    assign head_cur = pend_reg ? mem_rdata : head_val_reg;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        head_val_next = head_cur;
        pend_next     = 1'b0;
        done_next     = 1'b0;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_waddr     = ring_addr(head_reg, count_reg[AW-1:0]);
        mem_wdata     = req.push_value;
        mem_raddr     = ring_addr(head_reg, AW'(1));
        sort_go       = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    case (req.operation)
                        OP_PUSH:
                        begin
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                status_next = ST_PUSH_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (count_reg == '0)
                                begin
                                    head_val_next = req.push_value;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_POP_EMPTY;
                            end
                            else
                            begin
                                head_next  = ring_addr(head_reg, AW'(1));
                                count_next = count_reg - CW'(1);
                                pend_next  = count_reg > CW'(1);
                            end
                        end
                        OP_ROTATE:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = head_cur;
                                head_next = ring_addr(head_reg, AW'(1));
                                pend_next = 1'b1;
                            end
                        end
                        OP_SORT:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                done_next  = 1'b0;
                                sort_go    = 1'b1;
                                state_next = SORT;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            SORT:
            begin
                mem_we    = sort_wr_en;
                mem_waddr = ring_addr(head_reg, sort_wr_off);
                mem_wdata = sort_wr_data;
                mem_raddr = ring_addr(head_reg, sort_rd_off);
                if (sort_done)
                begin
                    // fetch the new head (the minimum) for the result beat
                    mem_raddr  = head_reg;
                    pend_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_val_reg <= head_val_next;
    end

    assign done = done_reg;

    always_comb
    begin
        result.head_value  = (count_reg == '0) ? '0 : $signed(head_cur);
        result.entry_count = COUNT_OUT_W'(count_reg);
        result.is_empty    = count_reg == '0;
        result.status      = status_reg;
    end

    `FQS_ASSERT(a_count_bound, count_reg <= CW'(QUEUE_DEPTH))
    `FQS_ASSERT(a_done_cause, done |-> $past(accept || sort_done))
    `FQS_ASSERT(a_sort_only_busy, sort_active |-> (busy || $past(sort_go)))
    `FQS_ASSERT(a_pend_nonempty, pend_reg |-> (count_reg != '0))

endmodule
